[rtl/pbu_pkg.sv]
// Shared types, constants and divide helper for the pixel blend unit.
package pbu_pkg;

   localparam int unsigned ChanW   = 8;
   localparam int unsigned NumChan = 3;
   localparam int unsigned PixelW  = 32;

   localparam logic [ChanW-1:0]         ChanMax          = 8'd255;
   localparam logic [NumChan*ChanW-1:0] RgbMask          = 24'hffffff;
   localparam logic [ChanW-1:0]         GlobalAlphaReset = 8'd255;

   typedef enum logic [2:0] {
      MODE_COPY,
      MODE_NORMAL,
      MODE_SRC_ALPHA,
      MODE_COLORKEY,
      MODE_ADD,
      MODE_MULTIPLY,
      MODE_FILL,
      MODE_UNUSED
   } blend_mode_type;

   typedef enum logic [1:0] {
      CSR_BLEND_MODE,
      CSR_GLOBAL_ALPHA,
      CSR_COLOR_KEY,
      CSR_FILL_COLOR
   } csr_index_type;

   typedef logic [NumChan-1:0][ChanW-1:0] rgb_type;

   typedef struct packed {
      logic              valid;
      blend_mode_type    mode;
      logic              row_end;
      logic              key_hit;
      logic              white;
      logic [PixelW-1:0] dest;
      logic [PixelW-1:0] src;
      logic [ChanW-1:0]  alpha;
      rgb_type           quot;
   } prep_type;

   // floor(x / 255), exact for x up to 255 * 255
   function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
      logic [2*ChanW:0] t;
      t = {1'b0, x} + (2*ChanW+1)'(x[2*ChanW-1:ChanW]) + (2*ChanW+1)'(1);
      return t[2*ChanW-1:ChanW];
   endfunction

endpackage

[rtl/pixel_blend_unit.sv]
// Top level of the ARGB8888 pixel blend unit: control registers and the four-stage pipeline.
//
// Usage:
//   Request: drive req_dest_pixel, req_source_pixel and req_row_end with start high.
//   The word is taken at a rising edge where start is high and busy is low.
//   busy is high only during reset, so one word can be taken every cycle.
//   Response: rsp_strobe is high for one cycle with rsp_blended_pixel and
//   rsp_row_end_out; the receiver must take it in that cycle, there is no stall.
//   Result path: a taken word passes the registers for products, divide/alpha,
//   blend products and final divide/select, in that order.
//   Throughput: one word per cycle, set by the fully pipelined multipliers.
//   Words come out in the order they went in.
//   Control registers: write csr_wdata to register csr_index when csr_write_enable
//   is high (0 blend_mode, 1 global_alpha, 2 color_key, 3 fill_color). Write them
//   only while no word is in flight.
//   Reset: synchronous; clears the pipeline, sets blend_mode to copy,
//   global_alpha to 255 and the color registers to zero.
module pixel_blend_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pbu_pkg::PixelW-1:0]   req_dest_pixel,
   input  logic [pbu_pkg::PixelW-1:0]   req_source_pixel,
   input  logic                         req_row_end,
   output logic                         rsp_strobe,
   output logic [pbu_pkg::PixelW-1:0]   rsp_blended_pixel,
   output logic                         rsp_row_end_out,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [pbu_pkg::PixelW-1:0]   csr_wdata
);
   import pbu_pkg::*;

   blend_mode_type       mode_ff;
   logic [ChanW-1:0]     global_alpha_ff;
   logic [PixelW-1:0]    color_key_ff;
   logic [PixelW-1:0]    fill_color_ff;

   logic                 accept;
   prep_type             prep;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_COPY;
         global_alpha_ff <= GlobalAlphaReset;
         color_key_ff    <= '0;
         fill_color_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLEND_MODE:   mode_ff         <= blend_mode_type'(csr_wdata[2:0]);
            CSR_GLOBAL_ALPHA: global_alpha_ff <= csr_wdata[ChanW-1:0];
            CSR_COLOR_KEY:    color_key_ff    <= csr_wdata;
            CSR_FILL_COLOR:   fill_color_ff   <= csr_wdata;
            default:          mode_ff         <= mode_ff;
         endcase
      end
   end

   assign busy   = reset;
   assign accept = start & ~busy;

   pbu_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .dest_pixel   (req_dest_pixel),
      .source_pixel (req_source_pixel),
      .row_end      (req_row_end),
      .mode         (mode_ff),
      .global_alpha (global_alpha_ff),
      .color_key    (color_key_ff),
      .fill_color   (fill_color_ff),
      .prep_out     (prep)
   );

   pbu_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .prep_in     (prep),
      .out_valid   (rsp_strobe),
      .out_pixel   (rsp_blended_pixel),
      .out_row_end (rsp_row_end_out)
   );

endmodule

[rtl/pbu_prep.sv]
// Front stages: source select, alpha and per-channel scale products, then divide by 255.
module pbu_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [pbu_pkg::PixelW-1:0]   dest_pixel,
   input  logic [pbu_pkg::PixelW-1:0]   source_pixel,
   input  logic                         row_end,
   input  pbu_pkg::blend_mode_type      mode,
   input  logic [pbu_pkg::ChanW-1:0]    global_alpha,
   input  logic [pbu_pkg::PixelW-1:0]   color_key,
   input  logic [pbu_pkg::PixelW-1:0]   fill_color,
   output pbu_pkg::prep_type            prep_out
);
   import pbu_pkg::*;

   logic                  a_valid_ff;
   blend_mode_type        a_mode_ff;
   logic                  a_row_end_ff;
   logic                  a_key_hit_ff;
   logic                  a_white_ff;
   logic [PixelW-1:0]     a_dest_ff;
   logic [PixelW-1:0]     a_src_ff;
   logic [ChanW-1:0]      a_ga_ff;
   logic [2*ChanW-1:0]    a_pa_ff;
   logic [NumChan-1:0][2*ChanW-1:0] a_prod_ff;

   logic [PixelW-1:0]     src_sel_in;
   logic [2*ChanW-1:0]    a_pa_in;
   logic [NumChan-1:0][2*ChanW-1:0] a_prod_in;

   prep_type              b_ff;
   prep_type              b_in;

   assign src_sel_in = (mode == MODE_FILL) ? fill_color : source_pixel;
   assign a_pa_in    = source_pixel[PixelW-1 -: ChanW] * global_alpha;

   for (genvar ch = 0; ch < NumChan; ch++) begin : g_prod
      logic [ChanW-1:0] sc;
      assign sc = src_sel_in[ch*ChanW +: ChanW];
      // multiply mode scales the distance from white
      assign a_prod_in[ch] = ((mode == MODE_MULTIPLY) ? (ChanMax - sc) : sc) * global_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_mode_ff    <= mode;
      a_row_end_ff <= row_end;
      a_key_hit_ff <= (source_pixel == color_key);
      a_white_ff   <= (source_pixel[NumChan*ChanW-1:0] == RgbMask);
      a_dest_ff    <= dest_pixel;
      a_src_ff     <= src_sel_in;
      a_ga_ff      <= global_alpha;
      a_pa_ff      <= a_pa_in;
      a_prod_ff    <= a_prod_in;
   end

   always_comb begin
      b_in.valid   = a_valid_ff;
      b_in.mode    = a_mode_ff;
      b_in.row_end = a_row_end_ff;
      b_in.key_hit = a_key_hit_ff;
      b_in.white   = a_white_ff;
      b_in.dest    = a_dest_ff;
      b_in.src     = a_src_ff;
      unique case (a_mode_ff)
         MODE_COPY:      b_in.alpha = ChanMax;
         MODE_SRC_ALPHA: b_in.alpha = div255(a_pa_ff);
         default:        b_in.alpha = a_ga_ff;
      endcase
      for (int ch = 0; ch < NumChan; ch++) begin
         b_in.quot[ch] = div255(a_prod_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else begin
         b_ff <= b_in;
      end
   end

   assign prep_out = b_ff;

endmodule

[rtl/pbu_mix.sv]
// Back stages: per-channel blend products, divide by 255, final pixel select.
module pbu_mix (
   input  logic                         clock,
   input  logic                         reset,
   input  pbu_pkg::prep_type            prep_in,
   output logic                         out_valid,
   output logic [pbu_pkg::PixelW-1:0]   out_pixel,
   output logic                         out_row_end
);
   import pbu_pkg::*;

   logic                  c_valid_ff;
   blend_mode_type        c_mode_ff;
   logic                  c_row_end_ff;
   logic                  c_key_hit_ff;
   logic                  c_white_ff;
   logic [PixelW-1:0]     c_dest_ff;
   logic [PixelW-1:0]     c_src_ff;
   logic [NumChan-1:0][2*ChanW-1:0] c_mag_ff;
   logic [NumChan-1:0][2*ChanW-1:0] c_mag_in;
   logic [NumChan-1:0]    c_neg_ff;
   logic [NumChan-1:0]    c_neg_in;
   rgb_type               c_sat_ff;
   rgb_type               c_sat_in;

   rgb_type               lerp_rgb;
   rgb_type               mul_rgb;

   logic                  out_valid_ff;
   logic [PixelW-1:0]     out_pixel_ff;
   logic [PixelW-1:0]     out_pixel_in;
   logic                  out_row_end_ff;

   for (genvar ch = 0; ch < NumChan; ch++) begin : g_chan
      logic [ChanW-1:0] dc;
      logic [ChanW-1:0] sc;
      logic [ChanW-1:0] qc;
      logic [ChanW:0]   sum;
      logic [ChanW-1:0] q_out;
      logic [ChanW-1:0] dc_out;

      assign dc  = prep_in.dest[ch*ChanW +: ChanW];
      assign sc  = prep_in.src[ch*ChanW +: ChanW];
      assign qc  = prep_in.quot[ch];
      assign sum = {1'b0, dc} + {1'b0, qc};

      always_comb begin
         c_neg_in[ch] = 1'b0;
         c_sat_in[ch] = sum[ChanW] ? ChanMax : sum[ChanW-1:0];
         if (prep_in.mode == MODE_MULTIPLY) begin
            c_mag_in[ch] = dc * (ChanMax - qc);
         end else if (sc >= dc) begin
            c_mag_in[ch] = (sc - dc) * prep_in.alpha;
         end else begin
            c_mag_in[ch] = (dc - sc) * prep_in.alpha;
            c_neg_in[ch] = 1'b1;
         end
      end

      // magnitude divide gives truncation toward zero
      assign q_out  = div255(c_mag_ff[ch]);
      assign dc_out = c_dest_ff[ch*ChanW +: ChanW];
      assign lerp_rgb[ch] = c_neg_ff[ch] ? (dc_out - q_out) : (dc_out + q_out);
      assign mul_rgb[ch]  = q_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= prep_in.valid;
      end
      c_mode_ff    <= prep_in.mode;
      c_row_end_ff <= prep_in.row_end;
      c_key_hit_ff <= prep_in.key_hit;
      c_white_ff   <= prep_in.white;
      c_dest_ff    <= prep_in.dest;
      c_src_ff     <= prep_in.src;
      c_mag_ff     <= c_mag_in;
      c_neg_ff     <= c_neg_in;
      c_sat_ff     <= c_sat_in;
   end

   always_comb begin
      unique case (c_mode_ff) inside
         MODE_COPY, MODE_NORMAL, MODE_SRC_ALPHA, MODE_FILL: begin
            out_pixel_in = {c_dest_ff[PixelW-1 -: ChanW], lerp_rgb};
         end
         MODE_COLORKEY: begin
            out_pixel_in = c_key_hit_ff ? c_dest_ff : c_src_ff;
         end
         MODE_ADD: begin
            out_pixel_in = {c_dest_ff[PixelW-1 -: ChanW], c_sat_ff};
         end
         MODE_MULTIPLY: begin
            out_pixel_in = c_white_ff ? c_dest_ff : {c_dest_ff[PixelW-1 -: ChanW], mul_rgb};
         end
         default: begin
            out_pixel_in = c_dest_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= c_valid_ff;
      end
      out_pixel_ff   <= out_pixel_in;
      out_row_end_ff <= c_row_end_ff;
   end

   assign out_valid   = out_valid_ff;
   assign out_pixel   = out_pixel_ff;
   assign out_row_end = out_row_end_ff;

endmodule

[rtl/pbu_checker.sv]
// Port-level checks for the pixel blend unit and the bind that attaches them.
module pbu_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_row_end,
   input logic rsp_strobe,
   input logic rsp_row_end_out
);

   logic accept;
   assign accept = start & ~busy;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe after reset");

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("taken word not returned after 4 cycles");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##4 !rsp_strobe)
      else $error("response without request");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_row_end_out == $past(req_row_end, 4)))
      else $error("row end flag mismatch");

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_row_end     (req_row_end),
   .rsp_strobe      (rsp_strobe),
   .rsp_row_end_out (rsp_row_end_out)
);

[tb/pixel_blend_checker.sv]
// Checker for the pixel blend unit: tracks the control registers, predicts and compares results.
module pixel_blend_checker
   import pbu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [PixelW-1:0] req_dest_pixel,
   input  logic [PixelW-1:0] req_source_pixel,
   input  logic              req_row_end,
   input  logic              rsp_strobe,
   input  logic [PixelW-1:0] rsp_blended_pixel,
   input  logic              rsp_row_end_out,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [PixelW-1:0] csr_wdata,
   output int                pending,
   output int                fail_count,
   output int                compared
);

   typedef struct packed {
      logic [PixelW-1:0] pixel;
      logic              row_end;
   } blended_word_type;

   blended_word_type expected_pixels[$];
   blend_mode_type   mode_reg;
   logic [7:0]       alpha_reg;
   logic [31:0]      key_reg;
   logic [31:0]      fill_reg;
   int               errors;
   int               checked;

   initial begin
      errors     = 0;
      checked    = 0;
      mode_reg   = MODE_COPY;
      alpha_reg  = GlobalAlphaReset;
      key_reg    = '0;
      fill_reg   = '0;
   end

   // d + trunc((s - d) * a / 255) on R, G and B; destination alpha kept
   function automatic logic [31:0] mix_rgb(logic [31:0] d, logic [31:0] s, int a);
      logic [31:0] res;
      int          dc;
      int          sc;
      int          ch;
      res = d;
      for (int i = 0; i < 3; i++) begin
         dc = int'(d[8*i +: 8]);
         sc = int'(s[8*i +: 8]);
         ch = dc + (sc - dc) * a / 255;
         res[8*i +: 8] = ch[7:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] blend_pixel(blend_mode_type m, logic [7:0] ga,
                                                logic [31:0] key, logic [31:0] fill,
                                                logic [31:0] d, logic [31:0] s);
      logic [31:0] res;
      int          a;
      int          dc;
      int          sc;
      int          f;
      int          ch;
      a   = int'(ga);
      res = d;
      case (m)
         MODE_COPY:      res = mix_rgb(d, s, 255);
         MODE_NORMAL:    res = mix_rgb(d, s, a);
         MODE_SRC_ALPHA: res = mix_rgb(d, s, int'(s[31:24]) * a / 255);
         MODE_COLORKEY:  res = (s != key) ? s : d;
         MODE_ADD: begin
            for (int i = 0; i < 3; i++) begin
               dc = int'(d[8*i +: 8]);
               sc = int'(s[8*i +: 8]);
               ch = dc + sc * a / 255;
               if (ch > 255) ch = 255;
               res[8*i +: 8] = ch[7:0];
            end
         end
         MODE_MULTIPLY: begin
            // white source leaves the destination alone
            if (s[23:0] != 24'hffffff) begin
               for (int i = 0; i < 3; i++) begin
                  dc = int'(d[8*i +: 8]);
                  sc = int'(s[8*i +: 8]);
                  f  = 255 + (sc - 255) * a / 255;
                  ch = dc * f / 255;
                  res[8*i +: 8] = ch[7:0];
               end
            end
         end
         MODE_FILL: res = mix_rgb(d, fill, a);
         default:   res = d;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      blended_word_type want;
      if (reset) begin
         expected_pixels.delete();
         mode_reg  = MODE_COPY;
         alpha_reg = GlobalAlphaReset;
         key_reg   = '0;
         fill_reg  = '0;
      end else begin
         if (start && !busy) begin
            want.pixel   = blend_pixel(mode_reg, alpha_reg, key_reg, fill_reg,
                                       req_dest_pixel, req_source_pixel);
            want.row_end = req_row_end;
            expected_pixels.push_back(want);
         end
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected word pixel %h row_end %b", $time,
                        rsp_blended_pixel, rsp_row_end_out);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               checked++;
               if (rsp_blended_pixel !== want.pixel) begin
                  $display("%0t: blended_pixel expected %h got %h", $time,
                           want.pixel, rsp_blended_pixel);
                  errors++;
               end
               if (rsp_row_end_out !== want.row_end) begin
                  $display("%0t: row_end_out expected %b got %b", $time,
                           want.row_end, rsp_row_end_out);
                  errors++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_BLEND_MODE:   mode_reg  = blend_mode_type'(csr_wdata[2:0]);
               CSR_GLOBAL_ALPHA: alpha_reg = csr_wdata[7:0];
               CSR_COLOR_KEY:    key_reg   = csr_wdata;
               CSR_FILL_COLOR:   fill_reg  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending    <= expected_pixels.size();
      fail_count <= errors;
      compared   <= checked;
   end

endmodule

[tb/pixel_blend_unit_test.sv]
// Testbench top for the pixel blend unit: clock, reset, stimulus and verdict.
module pixel_blend_unit_test;
   import pbu_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int NUM_PHASES   = 21;
   localparam int PHASE_WORDS  = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_dest_pixel = '0;
   logic [31:0] req_source_pixel = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_strobe;
   logic [31:0] rsp_blended_pixel;
   logic        rsp_row_end_out;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          pending;
   int          fail_count;
   int          compared;
   int          words_sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pixel_blend_unit DUT (
      .clock, .reset, .start, .busy,
      .req_dest_pixel, .req_source_pixel, .req_row_end,
      .rsp_strobe, .rsp_blended_pixel, .rsp_row_end_out,
      .csr_write_enable, .csr_index, .csr_wdata
   );

   pixel_blend_checker checker_i (
      .clock, .reset, .start, .busy,
      .req_dest_pixel, .req_source_pixel, .req_row_end,
      .rsp_strobe, .rsp_blended_pixel, .rsp_row_end_out,
      .csr_write_enable, .csr_index, .csr_wdata,
      .pending, .fail_count, .compared
   );

   task automatic send_word(logic [31:0] d, logic [31:0] s, logic re, int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start            <= 1'b1;
      req_dest_pixel   <= d;
      req_source_pixel <= s;
      req_row_end      <= re;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // drains the pipeline before touching a register
   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_regs(blend_mode_type m, logic [7:0] ga, logic [31:0] key,
                           logic [31:0] fill);
      write_reg(CSR_BLEND_MODE, {$urandom_range(0, 1) ? $urandom() : 32'h0} & ~32'h7 | m);
      write_reg(CSR_GLOBAL_ALPHA, {$urandom_range(0, 1) ? $urandom() : 32'h0} & ~32'hff | ga);
      write_reg(CSR_COLOR_KEY, key);
      write_reg(CSR_FILL_COLOR, fill);
   endtask

   function automatic logic [31:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("%0d words driven through all eight blend modes, %0d results compared",
               words_sent, compared);
      $display("pixel_blend_unit verification failed");
      $finish;
   end

   initial begin
      blend_mode_type m;
      logic [7:0]     ga;
      logic [31:0]    key;
      logic [31:0]    fill;
      logic [31:0]    s;
      int             idle_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings are copy mode
      send_word(32'h0, 32'h0, 1'b0, 0);
      send_word(32'hffffffff, 32'hffffffff, 1'b1, 0);
      send_word(32'h12345678, 32'h87654321, 1'b0, 0);
      set_regs(MODE_NORMAL, 8'd0, 32'h0, 32'h0);
      send_word(32'ha5a5a5a5, 32'h5a5a5a5a, 1'b1, 0);
      set_regs(MODE_NORMAL, 8'd128, 32'h0, 32'h0);
      send_word(32'h00ff00ff, 32'hff00ff00, 1'b0, 0);
      send_word(32'hff00ff00, 32'h00ff00ff, 1'b1, 0);
      set_regs(MODE_SRC_ALPHA, 8'd255, 32'h0, 32'h0);
      send_word(32'h11223344, 32'hffccbbaa, 1'b0, 0);
      send_word(32'h11223344, 32'h00ccbbaa, 1'b1, 0);
      send_word(32'hffffffff, 32'h80000000, 1'b0, 0);
      set_regs(MODE_COLORKEY, 8'd255, 32'h11223344, 32'h0);
      send_word(32'hdeadbeef, 32'h11223344, 1'b1, 0);
      send_word(32'hdeadbeef, 32'h11223345, 1'b0, 0);
      send_word(32'hdeadbeef, 32'h0, 1'b1, 0);
      set_regs(MODE_ADD, 8'd255, 32'h0, 32'h0);
      send_word(32'hffffffff, 32'hffffffff, 1'b0, 0);
      send_word(32'h00000000, 32'h00804020, 1'b1, 0);
      set_regs(MODE_MULTIPLY, 8'd255, 32'h0, 32'h0);
      send_word(32'h12345678, 32'h00ffffff, 1'b0, 0);
      send_word(32'h12ffffff, 32'hff000000, 1'b1, 0);
      send_word(32'h89abcdef, 32'h80808080, 1'b0, 0);
      set_regs(MODE_FILL, 8'd77, 32'h0, 32'hff102030);
      send_word(32'h44556677, 32'hffffffff, 1'b1, 0);
      set_regs(MODE_UNUSED, 8'd99, 32'hffffffff, 32'hffffffff);
      send_word(32'hcafef00d, 32'h01020304, 1'b0, 0);
      send_word(32'h0, 32'hffffffff, 1'b1, 0);

      // random phases, no idling near the end
      for (int p = 0; p < NUM_PHASES; p++) begin
         m = (p < 16) ? blend_mode_type'(p % 8) : blend_mode_type'($urandom_range(0, 7));
         case ($urandom_range(0, 5))
            0:       ga = 8'd0;
            1:       ga = 8'd255;
            2:       ga = 8'd1;
            3:       ga = 8'd254;
            default: ga = 8'($urandom_range(0, 255));
         endcase
         key  = pick_pixel();
         fill = pick_pixel();
         set_regs(m, ga, key, fill);
         case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 35;
         endcase
         if (p >= NUM_PHASES - 4) idle_pct = 0;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            s = pick_pixel();
            if (m == MODE_COLORKEY && $urandom_range(0, 2) == 0) s = key;
            else if (m == MODE_COLORKEY && $urandom_range(0, 7) == 0)
               s = key ^ (32'h1 << $urandom_range(0, 31));
            else if (m == MODE_MULTIPLY && $urandom_range(0, 3) == 0)
               s = {s[31:24], 24'hffffff};
            send_word(pick_pixel(), s, 1'($urandom_range(0, 1)), idle_pct);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d words driven through all eight blend modes, %0d results compared",
               words_sent, compared);
      if (fail_count == 0) begin
         $display("pixel_blend_unit verification clean");
      end else begin
         $display("pixel_blend_unit verification failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/pbu_pkg.sv
rtl/pbu_prep.sv
rtl/pbu_mix.sv
rtl/pixel_blend_unit.sv
rtl/pbu_checker.sv
tb/pixel_blend_checker.sv
tb/pixel_blend_unit_test.sv
